// ===== rtl/utf8s_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, constants and byte classification for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam int WIN_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       replaced;
		logic       last;
	} emit_t;

	// full sequence length for a lead byte, 0 if it cannot start one
	function automatic logic [2:0] seq_length(input logic [7:0] b);
		logic [2:0] len;
		if (b <= 8'h7F) begin
			len = 3'd1;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			len = 3'd2;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			len = 3'd3;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	// continuation byte check at offset pos after the lead
	function automatic logic follower_ok(input logic [7:0] lead, input logic [1:0] pos,
			input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (pos == 2'd1) begin
			if (lead == 8'hE0) begin
				lo = 8'hA0;
			end else if (lead == 8'hED) begin
				hi = 8'h9F;
			end else if (lead == 8'hF0) begin
				lo = 8'h90;
			end else if (lead == 8'hF4) begin
				hi = 8'h8F;
			end
		end
		return (c >= lo) && (c <= hi);
	endfunction

endpackage

// ===== rtl/utf8s_in_reg.sv =====
// ----------------------------------------------------------------------------
// utf8s_in_reg
// Input register: holds one accepted byte until the scanner absorbs it.
// ----------------------------------------------------------------------------
module utf8s_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              absorb,
	output logic              s1_valid,
	output utf8s_pkg::item_t  s1_item
);

	logic             valid_s1;
	utf8s_pkg::item_t item_s1;

	assign in_ready = !valid_s1 || absorb;
	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (absorb) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data <= in_byte;
			item_s1.last <= in_last;
		end
	end

endmodule

// ===== rtl/utf8s_scan.sv =====
// ----------------------------------------------------------------------------
// utf8s_scan
// Byte window and sequence check; produces at most one output byte per advance.
// ----------------------------------------------------------------------------
module utf8s_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              s1_valid,
	input  utf8s_pkg::item_t  s1_item,
	output logic              absorb,
	output utf8s_pkg::emit_t  emit
);

	logic [7:0] win_q [utf8s_pkg::WIN_DEPTH];
	logic [2:0] cnt_q;
	logic       end_q;
	logic [1:0] rep_left_q;
	logic [1:0] copy_left_q;

	logic [7:0] e    [utf8s_pkg::WIN_DEPTH];
	logic [7:0] sh   [utf8s_pkg::WIN_DEPTH];
	logic [7:0] win_d[utf8s_pkg::WIN_DEPTH];
	logic [2:0] e_cnt;
	logic       e_end;
	logic [2:0] e_len;
	logic       e_fail;
	logic [2:0] head_len;
	logic       cur_fail;
	logic       cur_wait;
	logic       busy;
	logic       hungry;
	logic [2:0] cnt_d;
	logic       end_d;
	logic [1:0] rep_d;
	logic [1:0] copy_d;

	always_comb begin
		busy     = (rep_left_q != 2'd0) || (copy_left_q != 2'd0);
		head_len = utf8s_pkg::seq_length(win_q[0]);
		cur_fail = 1'b0;
		for (int k = 1; k < utf8s_pkg::WIN_DEPTH; k++) begin
			if (3'(k) < cnt_q && 3'(k) < head_len &&
					!utf8s_pkg::follower_ok(win_q[0], 2'(k), win_q[k])) begin
				cur_fail = 1'b1;
			end
		end
		cur_wait = (cnt_q != 3'd0) && !cur_fail && (cnt_q < head_len) && !end_q;
		hungry   = !busy && ((cnt_q == 3'd0) || cur_wait);
		absorb   = adv && hungry && s1_valid;

		e     = win_q;
		e_cnt = cnt_q;
		e_end = end_q;
		if (absorb) begin
			e[cnt_q[1:0]] = s1_item.data;
			e_cnt         = cnt_q + 3'd1;
			e_end         = s1_item.last;
		end

		e_len  = utf8s_pkg::seq_length(e[0]);
		e_fail = 1'b0;
		for (int k = 1; k < utf8s_pkg::WIN_DEPTH; k++) begin
			if (3'(k) < e_cnt && 3'(k) < e_len &&
					!utf8s_pkg::follower_ok(e[0], 2'(k), e[k])) begin
				e_fail = 1'b1;
			end
		end

		for (int j = 0; j < utf8s_pkg::WIN_DEPTH - 1; j++) begin
			sh[j] = e[j + 1];
		end
		sh[utf8s_pkg::WIN_DEPTH - 1] = e[utf8s_pkg::WIN_DEPTH - 1];

		emit   = '0;
		win_d  = win_q;
		cnt_d  = cnt_q;
		end_d  = end_q;
		rep_d  = rep_left_q;
		copy_d = copy_left_q;

		if (adv) begin
			if (rep_left_q != 2'd0) begin
				emit.valid    = 1'b1;
				emit.data     = (rep_left_q == 2'd2) ? utf8s_pkg::REPL_B1 : utf8s_pkg::REPL_B2;
				emit.replaced = 1'b1;
				emit.last     = end_q && (rep_left_q == 2'd1) && (cnt_q == 3'd0);
				rep_d         = rep_left_q - 2'd1;
			end else if (copy_left_q != 2'd0) begin
				emit.valid = 1'b1;
				emit.data  = win_q[0];
				emit.last  = end_q && (copy_left_q == 2'd1) && (cnt_q == 3'd1);
				win_d      = sh;
				cnt_d      = cnt_q - 3'd1;
				copy_d     = copy_left_q - 2'd1;
			end else if (e_cnt != 3'd0) begin
				win_d = e;
				cnt_d = e_cnt;
				end_d = e_end;
				if (e_len == 3'd1) begin
					emit.valid = 1'b1;
					emit.data  = e[0];
					emit.last  = e_end && (e_cnt == 3'd1);
					win_d      = sh;
					cnt_d      = e_cnt - 3'd1;
				end else if (e_len == 3'd0 || e_fail || (e_cnt < e_len && e_end)) begin
					emit.valid    = 1'b1;
					emit.data     = utf8s_pkg::REPL_B0;
					emit.replaced = 1'b1;
					win_d         = sh;
					cnt_d         = e_cnt - 3'd1;
					rep_d         = 2'd2;
				end else if (e_cnt >= e_len) begin
					emit.valid = 1'b1;
					emit.data  = e[0];
					win_d      = sh;
					cnt_d      = e_cnt - 3'd1;
					copy_d     = 2'(e_len - 3'd1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 3'd0;
			end_q       <= 1'b0;
			rep_left_q  <= 2'd0;
			copy_left_q <= 2'd0;
		end else begin
			cnt_q       <= cnt_d;
			end_q       <= end_d;
			rep_left_q  <= rep_d;
			copy_left_q <= copy_d;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

endmodule

// ===== rtl/utf8s_out_reg.sv =====
// ----------------------------------------------------------------------------
// utf8s_out_reg
// Output register: holds one result byte until the sink takes it.
// ----------------------------------------------------------------------------
module utf8s_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8s_pkg::emit_t  emit,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_replaced,
	output logic              out_last
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       replaced_q;
	logic       last_q;

	assign adv          = !valid_q || out_ready;
	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign out_replaced = replaced_q;
	assign out_last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit.valid) begin
			byte_q     <= emit.data;
			replaced_q <= emit.replaced;
			last_q     <= emit.last;
		end
	end

endmodule

// ===== rtl/utf8_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Streaming UTF-8 validator that replaces each rejected byte with EF BF BD.
// ----------------------------------------------------------------------------
// Bytes enter through an input register, collect in a four-byte window and
// leave through an output register, at most one output byte per cycle. ASCII
// streams at one byte per cycle while the sink is ready. The leading bytes
// of a multi-byte character are absorbed without output; once its last byte
// arrives the character leaves back to back, holding the input until it has
// left. Each rejected byte yields three output bytes and holds the input
// while they leave; bytes held behind a rejected lead are rescanned one per
// cycle while the sink is ready; the next byte is taken only once the window
// is empty or holds an unfinished character. The last output byte of a
// string carries out_last.
module utf8_sanitizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_replaced,
	output logic       out_last
);

	logic             absorb;
	logic             s1_valid;
	utf8s_pkg::item_t s1_item;
	utf8s_pkg::emit_t emit;
	logic             adv;

	utf8s_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.absorb   (absorb),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	utf8s_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.s1_valid (s1_valid),
		.s1_item  (s1_item),
		.absorb   (absorb),
		.emit     (emit)
	);

	utf8s_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit         (emit),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_replaced (out_replaced),
		.out_last     (out_last)
	);

endmodule

// ===== tb/sv/utf8_sanitizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer_test
// Drives byte strings into the sanitizer and checks every output transaction
// against a built-in sanitizing predictor: a directed set of edge cases
// first, then random strings of mostly well-formed characters with truncated
// sequences, corrupted bytes and noise bytes mixed in. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module utf8_sanitizer_test;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} raw_t;

	typedef struct {
		logic [7:0] data;
		logic       replaced;
		logic       last;
	} clean_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_replaced;
	logic       out_last;

	raw_t       text_q[$];
	clean_t     clean_q[$];
	logic [7:0] str_buf[$];
	logic [7:0] held_bytes[3];
	int         held_count = 0;
	int         sent = 0;
	int         cyc = 0;
	int         mismatches = 0;

	utf8_sanitizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_replaced(out_replaced),
		.out_last(out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int lead_len(input logic [7:0] b);
		if (b < 8'h80) return 1;
		if (b >= 8'hC2 && b < 8'hE0) return 2;
		if (b >= 8'hE0 && b < 8'hF0) return 3;
		if (b >= 8'hF0 && b < 8'hF5) return 4;
		return 0;
	endfunction

	function automatic bit cont_ok(input logic [7:0] lead, input int pos, input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (pos == 1) begin
			case (lead)
				8'hE0: lo = 8'hA0;
				8'hED: hi = 8'h9F;
				8'hF0: lo = 8'h90;
				8'hF4: hi = 8'h8F;
				default: ;
			endcase
		end
		return c >= lo && c <= hi;
	endfunction

	function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
		logic [7:0] win[4];
		clean_t     outs[12];
		int         n;
		int         i;
		int         k;
		int         need;
		int         avail;
		int         have;
		int         cnt;
		bit         ok;
		n = held_count;
		for (k = 0; k < n; k++) win[k] = held_bytes[k];
		win[n] = b;
		n++;
		i = 0;
		cnt = 0;
		while (i < n) begin
			need = lead_len(win[i]);
			avail = n - i;
			if (need == 1) begin
				outs[cnt] = '{data: win[i], replaced: 1'b0, last: 1'b0};
				cnt++;
				i++;
			end else begin
				ok = need != 0;
				have = avail < need ? avail : need;
				for (k = 1; k < have && ok; k++) ok = cont_ok(win[i], k, win[i + k]);
				if (!ok || (avail < need && fin)) begin
					outs[cnt] = '{data: utf8s_pkg::REPL_B0, replaced: 1'b1, last: 1'b0};
					outs[cnt + 1] = '{data: utf8s_pkg::REPL_B1, replaced: 1'b1, last: 1'b0};
					outs[cnt + 2] = '{data: utf8s_pkg::REPL_B2, replaced: 1'b1, last: 1'b0};
					cnt += 3;
					i++;
				end else if (avail < need) begin
					break;
				end else begin
					for (k = 0; k < need; k++) begin
						outs[cnt] = '{data: win[i + k], replaced: 1'b0, last: 1'b0};
						cnt++;
					end
					i += need;
				end
			end
		end
		held_count = n - i;
		for (k = 0; k < held_count; k++) held_bytes[k] = win[i + k];
		if (fin && cnt > 0) outs[cnt - 1].last = 1'b1;
		for (k = 0; k < cnt; k++) clean_q.insert(clean_q.size(), outs[k]);
	endfunction

	task automatic push_raw(input logic [7:0] b, input logic fin);
		raw_t item;
		item.data = b;
		item.last = fin;
		text_q.insert(text_q.size(), item);
	endtask

	// one random character into str_buf, sometimes broken
	task automatic add_char();
		int unsigned cp;
		int          len;
		int          pick;
		int          k;
		logic [7:0]  b[4];
		pick = $urandom_range(0, 99);
		len = $urandom_range(1, 4);
		case (len)
			1: cp = $urandom_range(0, 'h7F);
			2: cp = $urandom_range('h80, 'h7FF);
			3: begin
				cp = $urandom_range('h800, 'hFFFF);
				if (cp >= 'hD800 && cp <= 'hDFFF) cp ^= 'h1000;
			end
			default: cp = $urandom_range('h10000, 'h10FFFF);
		endcase
		case (len)
			1: b[0] = cp[7:0];
			2: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			3: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		if (pick >= 75 && pick < 83 && len > 1) begin
			len = $urandom_range(1, len - 1);
		end else if (pick >= 83 && pick < 91) begin
			b[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
		end else if (pick >= 91) begin
			b[0] = 8'($urandom_range(0, 255));
			len = 1;
		end
		for (k = 0; k < len; k++) str_buf.insert(str_buf.size(), b[k]);
	endtask

	always @(posedge clk) begin
		logic go;
		raw_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sanitize_byte(in_byte, in_last);
				sent++;
			end
			if (!in_valid || in_ready) begin
				go = text_q.size() != 0 &&
					((sent >= 150 && sent < 240) || $urandom_range(0, 99) >= 13);
				if (go) begin
					nxt = text_q.pop_front();
					in_byte <= nxt.data;
					in_last <= nxt.last;
				end
				in_valid <= go;
			end
		end
	end

	always @(posedge clk) begin
		clean_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (clean_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected transaction, byte %02h", out_byte));
				end else begin
					want = clean_q.pop_front();
					if (out_byte !== want.data)
						flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
					if (out_replaced !== want.replaced)
						flag_mismatch($sformatf("out_replaced %b, want %b", out_replaced,
							want.replaced));
					if (out_last !== want.last)
						flag_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
				end
			end
			cyc++;
			out_ready <= (cyc >= 1500 && cyc < 2600) || $urandom_range(0, 99) >= 13;
		end
	end

	initial begin
		int total;
		int nchars;
		int k;
		// plain and well-formed edges
		push_raw(8'h00, 1'b0);
		push_raw(8'h7F, 1'b0);
		push_raw(8'hC2, 1'b0);
		push_raw(8'h80, 1'b0);
		push_raw(8'hE0, 1'b0);
		push_raw(8'hA0, 1'b0);
		push_raw(8'h80, 1'b0);
		push_raw(8'hED, 1'b0);
		push_raw(8'h9F, 1'b0);
		push_raw(8'hBF, 1'b0);
		push_raw(8'hF4, 1'b0);
		push_raw(8'h8F, 1'b0);
		push_raw(8'hBF, 1'b0);
		push_raw(8'hBF, 1'b1);
		// bad leads, lone continuation, overlong, surrogate, above max, truncated at end
		push_raw(8'hC0, 1'b0);
		push_raw(8'hF5, 1'b0);
		push_raw(8'h80, 1'b0);
		push_raw(8'hE0, 1'b0);
		push_raw(8'h9F, 1'b0);
		push_raw(8'hED, 1'b0);
		push_raw(8'hA0, 1'b0);
		push_raw(8'hF0, 1'b0);
		push_raw(8'h8F, 1'b0);
		push_raw(8'hF4, 1'b0);
		push_raw(8'h90, 1'b0);
		push_raw(8'hFF, 1'b0);
		push_raw(8'hE2, 1'b0);
		push_raw(8'h82, 1'b1);
		total = 0;
		while (total < 315) begin
			str_buf.delete();
			nchars = $urandom_range(1, 10);
			repeat (nchars) add_char();
			for (k = 0; k < str_buf.size(); k++) push_raw(str_buf[k], k == str_buf.size() - 1);
			total += str_buf.size();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (text_q.size() != 0 || in_valid) @(posedge clk);
		while (clean_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/utf8s_pkg.sv
rtl/utf8s_in_reg.sv
rtl/utf8s_scan.sv
rtl/utf8s_out_reg.sv
rtl/utf8_sanitizer.sv
tb/sv/utf8_sanitizer_test.sv
